// File: rtl/core/mff_pkg.sv
// Package for the multichannel frame FIFO.
// Holds the sizes, the request and result structs, the op, status and command codes.
// No dependencies.
package mff_pkg;

    localparam int CAPACITY  = 1024;
    localparam int CHANNELS  = 4;
    localparam int MAX_BLOCK = 64;

    localparam int MAX_CH    = 4;
    localparam int SAMPLE_W  = 32;
    localparam int FRAME_W   = CHANNELS * SAMPLE_W;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int FILL_W    = IDX_W;
    localparam int LEN_W     = 7;
    localparam int CMP_W     = (FILL_W > LEN_W) ? FILL_W + 1 : LEN_W + 1;
    localparam int OUT_FILL_W = 10;
    localparam int Q_DEPTH   = 2;
    localparam int QPTR_W    = $clog2(Q_DEPTH);
    localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_STATS = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_FRAME     = 3'd0,
        ST_PUSH_OK   = 3'd1,
        ST_PUSH_DROP = 3'd2,
        ST_UNDERRUN  = 3'd3,
        ST_STATS     = 3'd4,
        ST_CLEARED   = 3'd5,
        ST_EMPTY     = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_POP,
        CMD_CLEAR,
        CMD_STATS
    } t_kind;

    typedef logic [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic [1:0]       op;
        logic             block_start;
        logic [6:0]       block_frames;
        logic [31:0]      sample_0;
        logic [31:0]      sample_1;
        logic [31:0]      sample_2;
        logic [31:0]      sample_3;
    } t_in_req;

    typedef struct packed {
        logic [2:0]       status;
        logic             last;
        logic [31:0]      out_sample_0;
        logic [31:0]      out_sample_1;
        logic [31:0]      out_sample_2;
        logic [31:0]      out_sample_3;
        logic [9:0]       fill_level;
        logic [31:0]      overrun_count;
        logic [31:0]      underrun_count;
        logic [63:0]      frames_in_total;
        logic [63:0]      frames_out_total;
    } t_out_res;

    // Decoded request as it waits between front and back.
    typedef struct packed {
        t_kind                    kind;
        logic                     start;
        logic [LEN_W-1:0]         len;
        logic [FRAME_W-1:0]       frame;
    } t_cmd;

endpackage

// File: rtl/core/mff_front.sv
// Front end of the multichannel frame FIFO: accepts requests, decodes and
// saturates lengths, and queues decoded commands for the back end.
// Depends on mff_pkg.
module mff_front import mff_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_req  i_data,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_take
);

    t_cmd                r_q [Q_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic [QPTR_W-1:0]   n_rd_ptr;
    logic [QCNT_W-1:0]   n_count;
    logic                accept;
    t_cmd                dec;
    t_sample             in_smp [MAX_CH];
    logic [LEN_W-1:0]    len_sat;

    assign o_stall     = (r_count == QCNT_W'(Q_DEPTH));
    assign accept      = i_valid && !o_stall;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        in_smp[0] = i_data.sample_0;
        in_smp[1] = i_data.sample_1;
        in_smp[2] = i_data.sample_2;
        in_smp[3] = i_data.sample_3;
        len_sat = (i_data.block_frames > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK)
                                                             : i_data.block_frames;
        dec.start = i_data.block_start;
        dec.len   = len_sat;
        for (int c = 0; c < CHANNELS; c++) begin
            dec.frame[c*SAMPLE_W +: SAMPLE_W] = in_smp[c];
        end
        unique case (i_data.op)
            OP_PUSH: begin
                dec.kind = CMD_PUSH;
                // zero-length or unannounced frame counts as a block of one
                if (!i_data.block_start || len_sat == '0) begin
                    dec.len = LEN_W'(1);
                end
            end
            OP_POP:   dec.kind = CMD_POP;
            OP_CLEAR: dec.kind = CMD_CLEAR;
            default:  dec.kind = CMD_STATS;
        endcase
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (accept) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_cmd_take) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (accept && !i_cmd_take) begin
            n_count = r_count + 1'b1;
        end else if (!accept && i_cmd_take) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= dec;
        end
    end

endmodule

// File: rtl/core/mff_back.sv
// Back end of the multichannel frame FIFO: frame store, indices, counters,
// push admission, pop sequencing and the result register.
// Depends on mff_pkg.
module mff_back import mff_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_take,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_res  o_data
);

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [31:0]         r_overrun, n_overrun;
    logic [31:0]         r_underrun, n_underrun;
    logic [63:0]         r_in_cnt, n_in_cnt;
    logic [63:0]         r_out_cnt, n_out_cnt;
    logic [LEN_W-1:0]    r_push_left, n_push_left;
    logic                r_dropping, n_dropping;
    logic [LEN_W-1:0]    r_pop_left, n_pop_left;
    logic                r_o_valid, n_o_valid;
    t_out_res            r_o_data, n_o_data;

    logic [FRAME_W-1:0]  r_mem [CAPACITY];
    logic [FRAME_W-1:0]  r_rd_data;

    logic                out_free;
    logic                emit;
    logic                last;
    t_status             status;
    logic                mem_we;
    logic                new_blk;
    logic                drop;
    logic [LEN_W-1:0]    left_base;
    logic [FILL_W-1:0]   space;
    t_sample             smp [MAX_CH];

    assign out_free = !r_o_valid || !i_stall;
    assign space    = FILL_W'(CAPACITY - 1) - r_fill;
    assign o_valid  = r_o_valid;
    assign o_data   = r_o_data;

    always_comb begin
        n_state     = r_state;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_fill      = r_fill;
        n_overrun   = r_overrun;
        n_underrun  = r_underrun;
        n_in_cnt    = r_in_cnt;
        n_out_cnt   = r_out_cnt;
        n_push_left = r_push_left;
        n_dropping  = r_dropping;
        n_pop_left  = r_pop_left;
        o_cmd_take  = 1'b0;
        emit        = 1'b0;
        last        = 1'b1;
        status      = ST_STATS;
        mem_we      = 1'b0;
        new_blk     = 1'b0;
        drop        = 1'b0;
        left_base   = r_push_left;
        for (int c = 0; c < MAX_CH; c++) begin
            smp[c] = '0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_take = 1'b1;
                    unique case (i_cmd.kind)
                        CMD_PUSH: begin
                            emit    = 1'b1;
                            new_blk = i_cmd.start || (r_push_left == '0);
                            drop    = new_blk ? (CMP_W'(i_cmd.len) > CMP_W'(space))
                                              : r_dropping;
                            if (new_blk && drop) begin
                                n_overrun = r_overrun + 1'b1;
                            end
                            if (drop) begin
                                status = ST_PUSH_DROP;
                            end else begin
                                status   = ST_PUSH_OK;
                                mem_we   = 1'b1;
                                n_wr_idx = (r_wr_idx == IDX_W'(CAPACITY - 1)) ? '0
                                                                           : r_wr_idx + 1'b1;
                                n_fill   = r_fill + 1'b1;
                                n_in_cnt = r_in_cnt + 1'b1;
                            end
                            left_base   = new_blk ? i_cmd.len : r_push_left;
                            n_push_left = left_base - 1'b1;
                            n_dropping  = (n_push_left == '0) ? 1'b0 : drop;
                        end
                        CMD_POP: begin
                            if (i_cmd.len == '0) begin
                                emit   = 1'b1;
                                status = ST_EMPTY;
                            end else if (CMP_W'(i_cmd.len) > CMP_W'(r_fill)) begin
                                emit       = 1'b1;
                                status     = ST_UNDERRUN;
                                n_underrun = r_underrun + 1'b1;
                            end else begin
                                n_pop_left = i_cmd.len;
                                n_state    = S_POP;
                            end
                        end
                        CMD_CLEAR: begin
                            emit        = 1'b1;
                            status      = ST_CLEARED;
                            n_wr_idx    = '0;
                            n_rd_idx    = '0;
                            n_fill      = '0;
                            n_overrun   = '0;
                            n_underrun  = '0;
                            n_in_cnt    = '0;
                            n_out_cnt   = '0;
                            n_push_left = '0;
                            n_dropping  = 1'b0;
                        end
                        default: begin
                            emit   = 1'b1;
                            status = ST_STATS;
                        end
                    endcase
                end
            end
            default: begin
                if (out_free) begin
                    emit   = 1'b1;
                    status = ST_FRAME;
                    last   = (r_pop_left == LEN_W'(1));
                    for (int c = 0; c < CHANNELS; c++) begin
                        smp[c] = r_rd_data[c*SAMPLE_W +: SAMPLE_W];
                    end
                    n_rd_idx   = (r_rd_idx == IDX_W'(CAPACITY - 1)) ? '0 : r_rd_idx + 1'b1;
                    n_fill     = r_fill - 1'b1;
                    n_out_cnt  = r_out_cnt + 1'b1;
                    n_pop_left = r_pop_left - 1'b1;
                    if (last) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase

        n_o_valid = emit || (r_o_valid && i_stall);

        n_o_data.status           = status;
        n_o_data.last             = last;
        n_o_data.out_sample_0     = smp[0];
        n_o_data.out_sample_1     = smp[1];
        n_o_data.out_sample_2     = smp[2];
        n_o_data.out_sample_3     = smp[3];
        n_o_data.fill_level       = OUT_FILL_W'(n_fill);
        n_o_data.overrun_count    = n_overrun;
        n_o_data.underrun_count   = n_underrun;
        n_o_data.frames_in_total  = n_in_cnt;
        n_o_data.frames_out_total = n_out_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_fill      <= '0;
            r_overrun   <= '0;
            r_underrun  <= '0;
            r_in_cnt    <= '0;
            r_out_cnt   <= '0;
            r_push_left <= '0;
            r_dropping  <= 1'b0;
            r_pop_left  <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_fill      <= n_fill;
            r_overrun   <= n_overrun;
            r_underrun  <= n_underrun;
            r_in_cnt    <= n_in_cnt;
            r_out_cnt   <= n_out_cnt;
            r_push_left <= n_push_left;
            r_dropping  <= n_dropping;
            r_pop_left  <= n_pop_left;
            r_o_valid   <= n_o_valid;
        end
        if (emit) begin
            r_o_data <= n_o_data;
        end
    end

    // read address follows the next read index, so the registered read data is ready for the current read index
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_idx] <= i_cmd.frame;
        end
        r_rd_data <= r_mem[n_rd_idx];
    end

endmodule

// File: rtl/core/multichannel_frame_fifo.sv
// Top level of the multichannel frame FIFO: front end decoder and queue,
// back end with frame store and result register.
// Depends on mff_pkg, mff_front, mff_back.
//
// Usage: requests enter on i_valid / o_stall / i_data, results leave on
// o_valid / i_stall / o_data. A request is taken at a clock edge with valid
// high and stall low. A push request yields one result; a pop request for N
// frames yields N frame results (one per cycle while the receiver takes them)
// or one underrun or empty result; clear and statistics yield one result each.
// The final result of each request has last set.
// Order: an accepted request is written into the queue, and the back end takes it
// from there; a single-result request has its result registered as it is taken,
// while a pop loads its count and first store read as it is taken and then
// registers its frames from S_POP. The back end runs one command at a time and
// takes no new command while a pop is still sending its frames.
// Reset (synchronous, active low) empties the FIFO and the queue and clears
// all counters; the frame store is only read where it was written since.
// When i_stall is high while a result is valid, the result register holds, the back end waits and the
// queue fills; o_stall rises once both queue entries are occupied.
module multichannel_frame_fifo import mff_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_req   i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_res  o_data
);

    logic  cmd_valid;
    logic  cmd_take;
    t_cmd  cmd;

    mff_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    mff_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

endmodule
